@@ hw/rtl/command_frame_csv_decimal_parser_core_defines.svh @@
// Assertion macros for the command frame CSV decimal parser.
// Depends on signals named clock and reset in the including module.
`ifndef COMMAND_FRAME_CSV_DECIMAL_PARSER_CORE_DEFINES_SVH
`define COMMAND_FRAME_CSV_DECIMAL_PARSER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define CFCSV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfcsv assertion failed");

// Check that a condition implies another in the following cycle
`define CFCSV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfcsv assertion failed");

`endif

@@ hw/rtl/cfcsv_pkg.sv @@
// Shared types and constants for the command frame CSV decimal parser.
// No dependencies; used by cfcsv_token and the top level.
`default_nettype none

package cfcsv_pkg;

   localparam int BYTE_W     = 8;
   localparam int CODE_W     = 16;
   localparam int POS_W      = 17;
   localparam int VALUE_W    = 15;
   localparam int INDEX_W    = 8;
   localparam int CSR_IDX_W  = 2;

   // Frame layout
   localparam logic [POS_W-1:0] POS_CMD_HI      = 17'd0;
   localparam logic [POS_W-1:0] POS_CMD_LO      = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_HI      = 17'd2;
   localparam logic [POS_W-1:0] POS_LEN_LO      = 17'd3;
   localparam logic [POS_W-1:0] LAST_OFFSET     = 17'd6;

   // Characters
   localparam logic [BYTE_W-1:0] SEP_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] SEP_END    = 8'hDD;
   localparam logic [BYTE_W-1:0] CHR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_PLUS   = 8'h2B;
   localparam logic [BYTE_W-1:0] CHR_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;

   // Register reset values
   localparam logic [CODE_W-1:0] INIT_CODE_RESET  = 16'd1;
   localparam logic [CODE_W-1:0] FETCH_CODE_RESET = 16'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INIT_CODE  = 2'd0,
      CSR_FETCH_CODE = 2'd1
   } csr_index_type;

   // Token scan phase: skipping blanks, in sign/digits, or number ended
   typedef enum logic [1:0] {
      TOK_LEAD = 2'd0,
      TOK_BODY = 2'd1,
      TOK_STOP = 2'd2
   } tok_phase_type;

   typedef struct packed {
      logic              clear;
      logic              push;
      logic [BYTE_W-1:0] ch;
   } tok_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/cfcsv_token.sv @@
// Token accumulator: evaluates the decimal value of a token as its characters arrive.
// Depends on cfcsv_pkg.
`default_nettype none

module cfcsv_token #(
   parameter int TOKEN_CHARS = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  cfcsv_pkg::tok_ctrl_type        ctrl,
   output logic signed [cfcsv_pkg::VALUE_W-1:0] value
);

   localparam int LEN_W = $clog2(TOKEN_CHARS + 1);

   cfcsv_pkg::tok_phase_type       phase_ff, phase_in;
   logic                           neg_ff, neg_in;
   logic [cfcsv_pkg::VALUE_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0]               len_ff, len_in;

   logic                           take;
   logic                           is_blank, is_sign, is_digit;
   logic [cfcsv_pkg::VALUE_W-1:0]  digit;

   // Classify the incoming character
   always_comb begin
      take     = ctrl.push && (len_ff < LEN_W'(TOKEN_CHARS));
      is_blank = (ctrl.ch == cfcsv_pkg::CHR_SPACE) ||
                 ((ctrl.ch >= cfcsv_pkg::CHR_TAB) && (ctrl.ch <= cfcsv_pkg::CHR_CR));
      is_sign  = (ctrl.ch == cfcsv_pkg::CHR_PLUS) || (ctrl.ch == cfcsv_pkg::CHR_MINUS);
      is_digit = (ctrl.ch >= cfcsv_pkg::CHR_ZERO) && (ctrl.ch <= cfcsv_pkg::CHR_NINE);
      digit    = cfcsv_pkg::VALUE_W'(ctrl.ch - cfcsv_pkg::CHR_ZERO);
   end

   // Next scan phase
   always_comb begin
      phase_in = phase_ff;
      if (ctrl.clear) begin
         phase_in = cfcsv_pkg::TOK_LEAD;
      end else if (take) begin
         case (phase_ff)
            cfcsv_pkg::TOK_LEAD: begin
               if (is_sign || is_digit) begin
                  phase_in = cfcsv_pkg::TOK_BODY;
               end else if (!is_blank) begin
                  phase_in = cfcsv_pkg::TOK_STOP;
               end
            end
            cfcsv_pkg::TOK_BODY: begin
               if (!is_digit) begin
                  phase_in = cfcsv_pkg::TOK_STOP;
               end
            end
            default: phase_in = cfcsv_pkg::TOK_STOP;
         endcase
      end
   end

   // Sign, accumulator and kept length
   always_comb begin
      neg_in = neg_ff;
      acc_in = acc_ff;
      len_in = len_ff;
      if (ctrl.clear) begin
         neg_in = 1'b0;
         acc_in = '0;
         len_in = '0;
      end else if (take) begin
         len_in = len_ff + LEN_W'(1);
         case (phase_ff)
            cfcsv_pkg::TOK_LEAD: begin
               if (is_sign) begin
                  neg_in = (ctrl.ch == cfcsv_pkg::CHR_MINUS);
               end else if (is_digit) begin
                  acc_in = digit;
               end
            end
            cfcsv_pkg::TOK_BODY: begin
               if (is_digit) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
               end
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfcsv_pkg::TOK_LEAD;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         len_ff   <= len_in;
      end
   end

   // Apply the sign, modulo the field width
   assign value = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

`default_nettype wire

@@ hw/rtl/command_frame_csv_decimal_parser_core.sv @@
// Top level of the command frame CSV decimal parser: frame decode, counters, result register.
// Depends on cfcsv_pkg, cfcsv_token and command_frame_csv_decimal_parser_core_defines.svh.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_rx_byte, req_frame_start
//   rsp     | out       | rsp_valid/rsp_ready | value_valid, parsed_value, value_index, ack_valid
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One byte is taken per cycle while req_ready is high; its result is registered and shown the following cycle.
// The result register is the only buffer: a new byte enters while the held result is taken.
// When a result is held and rsp_ready is low, req_ready drops until it is taken.
// Reset is synchronous; it restores the command codes and leaves the parser idle
// until a byte with frame_start arrives. csr_ready is always high.
`default_nettype none
`include "command_frame_csv_decimal_parser_core_defines.svh"

module command_frame_csv_decimal_parser_core #(
   parameter int MAX_VALUES  = 256,
   parameter int TOKEN_CHARS = 4
) (
   input  wire                                          clock,
   input  wire                                          reset,
   // Input transactions
   input  wire                                          req_valid,
   output logic                                         req_ready,
   input  wire  [cfcsv_pkg::BYTE_W-1:0]                 req_rx_byte,
   input  wire                                          req_frame_start,
   // Result transactions
   output logic                                         rsp_valid,
   input  wire                                          rsp_ready,
   output logic                                         rsp_value_valid,
   output logic signed [cfcsv_pkg::VALUE_W-1:0]         rsp_parsed_value,
   output logic [cfcsv_pkg::INDEX_W-1:0]                rsp_value_index,
   output logic                                         rsp_ack_valid,
   // Register writes
   input  wire                                          csr_valid,
   output logic                                         csr_ready,
   input  wire  [cfcsv_pkg::CSR_IDX_W-1:0]              csr_index,
   input  wire  [cfcsv_pkg::CODE_W-1:0]                 csr_data
);

   localparam int CNT_W = $clog2(MAX_VALUES + 1);

   // Command code registers
   logic [cfcsv_pkg::CODE_W-1:0]   init_code_ff, fetch_code_ff;

   // Frame state
   logic [cfcsv_pkg::POS_W-1:0]    pos_ff, pos_in, pos_cur;
   logic [cfcsv_pkg::BYTE_W-1:0]   cmd_hi_ff, cmd_hi_in;
   logic [cfcsv_pkg::CODE_W-1:0]   len_ff, len_in, len_cur;
   logic [CNT_W-1:0]               cnt_ff, cnt_in, cnt_cur;
   logic                           fin_ff, fin_in, fin_cur;

   // Result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 val_ff, ack_ff;
   logic signed [cfcsv_pkg::VALUE_W-1:0] value_ff;
   logic [cfcsv_pkg::INDEX_W-1:0]        index_ff;

   logic                           accept;
   logic                           payload, sep;
   logic                           res_val, res_ack;
   logic [cfcsv_pkg::INDEX_W-1:0]  res_idx;
   logic [cfcsv_pkg::CODE_W-1:0]   cmd_word;
   logic [CNT_W+cfcsv_pkg::INDEX_W-1:0] cnt_ext;
   logic [cfcsv_pkg::POS_W-1:0]    last_pos;

   cfcsv_pkg::tok_ctrl_type                tok_ctrl;
   logic signed [cfcsv_pkg::VALUE_W-1:0]   tok_value;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_code_ff  <= cfcsv_pkg::INIT_CODE_RESET;
         fetch_code_ff <= cfcsv_pkg::FETCH_CODE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cfcsv_pkg::CSR_INIT_CODE:  init_code_ff  <= csr_data;
            cfcsv_pkg::CSR_FETCH_CODE: fetch_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Decode the byte against the frame state; frame start clears the state first
   always_comb begin
      pos_cur   = req_frame_start ? '0 : pos_ff;
      len_cur   = req_frame_start ? '0 : len_ff;
      cnt_cur   = req_frame_start ? '0 : cnt_ff;
      fin_cur   = req_frame_start ? 1'b0 : fin_ff;
      cmd_hi_in = req_frame_start ? '0 : cmd_hi_ff;
      pos_in    = pos_cur;
      len_in    = len_cur;
      cnt_in    = cnt_cur;
      fin_in    = fin_cur;
      cmd_word  = {cmd_hi_ff, req_rx_byte};
      cnt_ext   = {{cfcsv_pkg::INDEX_W{1'b0}}, cnt_cur};
      last_pos  = {1'b0, len_cur} + cfcsv_pkg::LAST_OFFSET;
      sep       = (req_rx_byte == cfcsv_pkg::SEP_COMMA) || (req_rx_byte == cfcsv_pkg::SEP_END);
      payload   = 1'b0;
      res_val   = 1'b0;
      res_ack   = 1'b0;
      res_idx   = '0;
      if (!fin_cur) begin
         pos_in = pos_cur + 1'b1;
         if (pos_cur == cfcsv_pkg::POS_CMD_HI) begin
            cmd_hi_in = req_rx_byte;
         end else if (pos_cur == cfcsv_pkg::POS_CMD_LO) begin
            if (cmd_word == init_code_ff) begin
               res_ack = 1'b1;
               fin_in  = 1'b1;
            end else if (cmd_word != fetch_code_ff) begin
               fin_in  = 1'b1;
            end
         end else if (pos_cur == cfcsv_pkg::POS_LEN_HI) begin
            len_in[15:8] = req_rx_byte;
         end else if (pos_cur == cfcsv_pkg::POS_LEN_LO) begin
            len_in[7:0] = req_rx_byte;
         end else begin
            payload = 1'b1;
            if (sep) begin
               res_val = 1'b1;
               res_idx = cnt_ext[cfcsv_pkg::INDEX_W-1:0];
               cnt_in  = cnt_cur + 1'b1;
            end
            if ((pos_cur >= last_pos) || (cnt_in >= CNT_W'(MAX_VALUES))) begin
               res_ack = 1'b1;
               fin_in  = 1'b1;
            end
         end
      end
   end

   // Drive the token accumulator
   always_comb begin
      tok_ctrl.clear = accept && (req_frame_start || (payload && sep));
      tok_ctrl.push  = accept && payload && !sep && (req_rx_byte != cfcsv_pkg::CHR_NUL);
      tok_ctrl.ch    = req_rx_byte;
   end

   cfcsv_token #(
      .TOKEN_CHARS (TOKEN_CHARS)
   ) u_token (
      .clock (clock),
      .reset (reset),
      .ctrl  (tok_ctrl),
      .value (tok_value)
   );

   // Advance frame state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cmd_hi_ff <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         fin_ff    <= 1'b1;
      end else if (accept) begin
         pos_ff    <= pos_in;
         cmd_hi_ff <= cmd_hi_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
      end
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_val || res_ack;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff   <= res_val;
         ack_ff   <= res_ack;
         value_ff <= res_val ? tok_value : '0;
         index_ff <= res_idx;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_valid  = val_ff;
   assign rsp_parsed_value = value_ff;
   assign rsp_value_index  = index_ff;
   assign rsp_ack_valid    = ack_ff;

   // A held result always carries a value or an acknowledge
   `CFCSV_ASSERT_SAME(a_result_not_empty, rsp_valid_ff, val_ff || ack_ff)
   // An acknowledge finishes the frame
   `CFCSV_ASSERT_NEXT(a_ack_finishes, accept && res_ack, fin_ff)
   // An open frame never holds a full value table
   `CFCSV_ASSERT_SAME(a_count_bound, !fin_ff, cnt_ff < CNT_W'(MAX_VALUES))

endmodule

`default_nettype wire
